@@ src/la64id_pkg.sv @@
package la64id_pkg;

	typedef struct packed {
		logic [31:0] instr_word;
		logic        word_complete;
		logic [63:0] pc;
	} insn_t;

	typedef struct packed {
		logic [5:0]         insn_id;
		logic [4:0]         dest_reg;
		logic [4:0]         src_reg_j;
		logic [4:0]         src_reg_k;
		logic signed [19:0] immediate;
		logic [63:0]        branch_target;
		logic [2:0]         consumed_len;
	} dec_t;

	localparam logic [2:0] LEN_FULL = 3'd4;
	localparam logic [2:0] LEN_PART = 3'd1;

	// major opcodes, bits 31:26
	localparam logic [5:0] OP6_JIRL = 6'h13;
	localparam logic [5:0] OP6_B    = 6'h14;
	localparam logic [5:0] OP6_BL   = 6'h15;
	localparam logic [5:0] OP6_BEQ  = 6'h16;
	localparam logic [5:0] OP6_BGEU = 6'h1B;

	// bits 31:24
	localparam logic [7:0] OP8_BEQZ    = 8'h40;
	localparam logic [7:0] OP8_BNEZ    = 8'h44;
	localparam logic [7:0] OP8_LU12I   = 8'h14;
	localparam logic [7:0] OP8_LU32I   = 8'h16;
	localparam logic [7:0] OP8_PCALAU  = 8'h1A;
	localparam logic [7:0] OP8_SYSCALL = 8'h18;
	localparam logic [7:0] OP8_BREAK   = 8'hB0;
	localparam logic [7:0] OP8_BAR     = 8'h0B;
	localparam logic [4:0] BAR_DBAR    = 5'd0;
	localparam logic [4:0] BAR_IBCL    = 5'd4;

	// bits 31:22
	localparam logic [9:0] OP10_LD_B  = 10'h0A0;
	localparam logic [9:0] OP10_LD_WU = 10'h0AA;
	localparam logic [9:0] OP10_SLTI  = 10'h008;
	localparam logic [9:0] OP10_ADDID = 10'h00B;
	localparam logic [9:0] OP10_ANDI  = 10'h00D;
	localparam logic [9:0] OP10_XORI  = 10'h00F;

	// bits 31:15
	localparam logic [16:0] F17_ADD_W  = 17'h20;
	localparam logic [16:0] F17_ADD_D  = 17'h21;
	localparam logic [16:0] F17_SUB_W  = 17'h22;
	localparam logic [16:0] F17_SUB_D  = 17'h23;
	localparam logic [16:0] F17_SLT    = 17'h24;
	localparam logic [16:0] F17_SLTU   = 17'h25;
	localparam logic [16:0] F17_NOR    = 17'h28;
	localparam logic [16:0] F17_AND    = 17'h29;
	localparam logic [16:0] F17_OR     = 17'h2A;
	localparam logic [16:0] F17_XOR    = 17'h2B;
	localparam logic [16:0] F17_SLL_W  = 17'h2E;
	localparam logic [16:0] F17_SRL_W  = 17'h2F;
	localparam logic [16:0] F17_SRA_W  = 17'h30;
	localparam logic [16:0] F17_SLL_D  = 17'h31;
	localparam logic [16:0] F17_SRL_D  = 17'h32;
	localparam logic [16:0] F17_SRA_D  = 17'h33;
	localparam logic [16:0] F17_SLLI_W = 17'h81;
	localparam logic [16:0] F17_SLLI_D = 17'h82;
	localparam logic [16:0] F17_SRLI_W = 17'h89;
	localparam logic [16:0] F17_SRLI_D = 17'h8A;
	localparam logic [16:0] F17_SRAI_W = 17'h91;
	localparam logic [16:0] F17_SRAI_D = 17'h92;

	// instruction ids
	localparam logic [5:0] ID_INVALID   = 6'd0;
	localparam logic [5:0] ID_JIRL      = 6'd1;
	localparam logic [5:0] ID_B         = 6'd2;
	localparam logic [5:0] ID_BL        = 6'd3;
	localparam logic [5:0] ID_BEQ       = 6'd4;
	localparam logic [5:0] ID_BEQZ      = 6'd10;
	localparam logic [5:0] ID_BNEZ      = 6'd11;
	localparam logic [5:0] ID_LU12I_W   = 6'd12;
	localparam logic [5:0] ID_LU32I_D   = 6'd13;
	localparam logic [5:0] ID_LU52I_D   = 6'd14;
	localparam logic [5:0] ID_PCALAU12I = 6'd15;
	localparam logic [5:0] ID_LD_B      = 6'd16;
	localparam logic [5:0] ID_SYSCALL   = 6'd27;
	localparam logic [5:0] ID_BREAK     = 6'd28;
	localparam logic [5:0] ID_DBAR      = 6'd29;
	localparam logic [5:0] ID_IBCL      = 6'd30;
	localparam logic [5:0] ID_SLTI      = 6'd31;
	localparam logic [5:0] ID_ANDI      = 6'd35;
	localparam logic [5:0] ID_ADD_W     = 6'd38;
	localparam logic [5:0] ID_ADD_D     = 6'd39;
	localparam logic [5:0] ID_SUB_W     = 6'd40;
	localparam logic [5:0] ID_SUB_D     = 6'd41;
	localparam logic [5:0] ID_SLT       = 6'd42;
	localparam logic [5:0] ID_SLTU      = 6'd43;
	localparam logic [5:0] ID_NOR       = 6'd44;
	localparam logic [5:0] ID_AND       = 6'd45;
	localparam logic [5:0] ID_OR        = 6'd46;
	localparam logic [5:0] ID_XOR       = 6'd47;
	localparam logic [5:0] ID_SLL_W     = 6'd48;
	localparam logic [5:0] ID_SRL_W     = 6'd49;
	localparam logic [5:0] ID_SRA_W     = 6'd50;
	localparam logic [5:0] ID_SLL_D     = 6'd51;
	localparam logic [5:0] ID_SRL_D     = 6'd52;
	localparam logic [5:0] ID_SRA_D     = 6'd53;
	localparam logic [5:0] ID_SLLI_W    = 6'd54;
	localparam logic [5:0] ID_SLLI_D    = 6'd55;
	localparam logic [5:0] ID_SRLI_W    = 6'd56;
	localparam logic [5:0] ID_SRLI_D    = 6'd57;
	localparam logic [5:0] ID_SRAI_W    = 6'd58;
	localparam logic [5:0] ID_SRAI_D    = 6'd59;

endpackage

@@ src/la64_instruction_decoder.sv @@
// channel | dir | handshake               | beat
// insn    | in  | insn_valid / insn_stall | insn_t: instr_word, word_complete, pc
// dec     | out | dec_valid / dec_stall   | dec_t: id, regs, immediate, target, length
//
// An accepted insn beat reaches dec through the input register, then decode
// and 64-bit target add, then the result register.
// One beat per cycle sustained while dec_stall is low; each stage loads when empty or when its beat moves on.
// dec_stall backs up into insn_stall only once both stages hold a beat.
// arst_n clears the stage valid flags; payload registers are not reset.
module la64_instruction_decoder
	import la64id_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  insn_valid,
	output logic  insn_stall,
	input  insn_t insn,
	output logic  dec_valid,
	input  logic  dec_stall,
	output dec_t  dec
);

	insn_t insn_s1;
	logic  valid_s1;
	dec_t  dec_c;
	dec_t  dec_s2;
	logic  valid_s2;
	logic  adv_s2;

	la64id_dec u_dec (
		.insn (insn_s1),
		.dec  (dec_c)
	);

	assign adv_s2     = !valid_s2 || !dec_stall;
	assign insn_stall = valid_s1 && !adv_s2;
	assign dec_valid  = valid_s2;
	assign dec        = dec_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!insn_stall)
				valid_s1 <= insn_valid;
			if (adv_s2)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (insn_valid && !insn_stall)
			insn_s1 <= insn;
		if (adv_s2 && valid_s1)
			dec_s2 <= dec_c;
	end

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		insn_stall |-> (valid_s1 && valid_s2))
		else $error("insn stalled with a free stage");

	a_len_code: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (dec_s2.consumed_len == LEN_FULL || dec_s2.consumed_len == LEN_PART))
		else $error("bad consumed length");

	a_part_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && dec_s2.consumed_len == LEN_PART) |-> (dec_s2.insn_id == ID_INVALID))
		else $error("partial word decoded as instruction");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && dec_s2.insn_id == ID_INVALID) |->
		(dec_s2.branch_target == 64'd0 && dec_s2.immediate == 20'sd0 &&
		 dec_s2.dest_reg == 5'd0))
		else $error("invalid result carries fields");

	a_nonbranch_tgt: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && dec_s2.insn_id > ID_BNEZ) |-> (dec_s2.branch_target == 64'd0))
		else $error("target on non-branch");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && dec_stall) |=> (valid_s2 && $stable(dec_s2)))
		else $error("stalled result changed");

endmodule

@@ src/la64id_dec.sv @@
module la64id_dec
	import la64id_pkg::*;
(
	input  insn_t insn,
	output dec_t  dec
);

	logic [31:0] w;
	logic [5:0]  o6;
	logic [7:0]  o8;
	logic [9:0]  o10;
	logic [16:0] f17;
	logic [5:0]  id;
	logic [19:0] imm;
	logic [25:0] off;
	logic        br;
	logic [19:0] s12;
	logic [63:0] tgt;

	assign w   = insn.instr_word;
	assign o6  = w[31:26];
	assign o8  = w[31:24];
	assign o10 = w[31:22];
	assign f17 = w[31:15];
	assign s12 = {{8{w[21]}}, w[21:10]};

	always_comb begin
		id  = ID_INVALID;
		imm = '0;
		off = '0;
		br  = 1'b0;
		if (o6 == OP6_JIRL) begin
			id  = ID_JIRL;
			off = {{10{w[25]}}, w[25:10]};
			br  = 1'b1;
		end else if (o6 == OP6_B || o6 == OP6_BL) begin
			id  = (o6 == OP6_B) ? ID_B : ID_BL;
			off = w[25:0];
			br  = 1'b1;
		end else if (o6 >= OP6_BEQ && o6 <= OP6_BGEU) begin
			id  = ID_BEQ + (o6 - OP6_BEQ);
			off = {{10{w[25]}}, w[25:10]};
			br  = 1'b1;
		end else if (o8 == OP8_BEQZ || o8 == OP8_BNEZ) begin
			id  = (o8 == OP8_BEQZ) ? ID_BEQZ : ID_BNEZ;
			off = {{12{w[23]}}, w[23:10]};
			br  = 1'b1;
		end else if (o8 == OP8_LU12I && w[23:22] == 2'b00) begin
			id  = ID_LU12I_W;
			imm = w[24:5];
		end else if (o8 == OP8_LU32I && !w[23]) begin
			id  = ID_LU32I_D;
			imm = w[24:5];
		end else if (o8 == OP8_LU32I) begin
			id  = ID_LU52I_D;
			imm = s12;
		end else if (o8 == OP8_PCALAU) begin
			id  = ID_PCALAU12I;
			imm = w[24:5];
		end else if (o10 >= OP10_LD_B && o10 <= OP10_LD_WU) begin
			id  = ID_LD_B + 6'(o10 - OP10_LD_B);
			imm = s12;
		end else if (o8 == OP8_SYSCALL) begin
			id  = ID_SYSCALL;
			imm = {15'd0, w[4:0]};
		end else if (o8 == OP8_BREAK) begin
			id  = ID_BREAK;
			imm = {5'd0, w[24:10]};
		end else if (o8 == OP8_BAR && w[9:5] == BAR_DBAR) begin
			id  = ID_DBAR;
			imm = {15'd0, w[4:0]};
		end else if (o8 == OP8_BAR && w[9:5] == BAR_IBCL) begin
			id  = ID_IBCL;
		end else if (o10 >= OP10_SLTI && o10 <= OP10_ADDID) begin
			id  = ID_SLTI + 6'(o10 - OP10_SLTI);
			imm = s12;
		end else if (o10 >= OP10_ANDI && o10 <= OP10_XORI) begin
			id  = ID_ANDI + 6'(o10 - OP10_ANDI);
			imm = {8'd0, w[21:10]};
		end else begin
			unique case (f17)
				F17_ADD_W:  id = ID_ADD_W;
				F17_ADD_D:  id = ID_ADD_D;
				F17_SUB_W:  id = ID_SUB_W;
				F17_SUB_D:  id = ID_SUB_D;
				F17_SLT:    id = ID_SLT;
				F17_SLTU:   id = ID_SLTU;
				F17_NOR:    id = ID_NOR;
				F17_AND:    id = ID_AND;
				F17_OR:     id = ID_OR;
				F17_XOR:    id = ID_XOR;
				F17_SLL_W:  id = ID_SLL_W;
				F17_SRL_W:  id = ID_SRL_W;
				F17_SRA_W:  id = ID_SRA_W;
				F17_SLL_D:  id = ID_SLL_D;
				F17_SRL_D:  id = ID_SRL_D;
				F17_SRA_D:  id = ID_SRA_D;
				F17_SLLI_W: begin
					id  = ID_SLLI_W;
					imm = {15'd0, w[14:10]};
				end
				F17_SLLI_D: begin
					id  = ID_SLLI_D;
					imm = {14'd0, w[15:10]};
				end
				F17_SRLI_W: begin
					id  = ID_SRLI_W;
					imm = {15'd0, w[14:10]};
				end
				F17_SRLI_D: begin
					id  = ID_SRLI_D;
					imm = {14'd0, w[15:10]};
				end
				F17_SRAI_W: begin
					id  = ID_SRAI_W;
					imm = {15'd0, w[14:10]};
				end
				F17_SRAI_D: begin
					id  = ID_SRAI_D;
					imm = {14'd0, w[15:10]};
				end
				default: id = ID_INVALID;
			endcase
		end
	end

	// pc + 4 + 4 * offset, wraps at 64 bits
	assign tgt = insn.pc + 64'd4 + {{36{off[25]}}, off, 2'b00};

	always_comb begin
		dec = '0;
		if (!insn.word_complete) begin
			dec.consumed_len = LEN_PART;
		end else begin
			dec.consumed_len = LEN_FULL;
			if (id != ID_INVALID) begin
				dec.insn_id       = id;
				dec.dest_reg      = w[4:0];
				dec.src_reg_j     = w[9:5];
				dec.src_reg_k     = w[14:10];
				dec.immediate     = imm;
				dec.branch_target = br ? tgt : 64'd0;
			end
		end
	end

endmodule
